// ===== rtl/core/rsc_pkg.sv =====
// Shared types, codes and constants for the Reno sender window control block.
package rsc_pkg;

    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IDX_W       = 16;
    localparam int unsigned SEQ_W       = 8;
    localparam int unsigned WIN_W       = 6;
    localparam int unsigned PHASE_W     = 2;
    localparam int unsigned REQ_W       = 2;
    localparam int unsigned DUP_W       = 2;

    // Largest congestion window; cwnd saturates here.
    localparam logic [WIN_W-1:0] MAX_CWND      = 6'd62;
    localparam logic [WIN_W-1:0] INIT_SSTHRESH = 6'd32;
    localparam logic [WIN_W-1:0] RECOV_INFLATE = 6'd3;
    localparam logic [DUP_W:0]   DUP_THRESH    = 3'd3;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

    // Congestion control phases.
    localparam logic [PHASE_W-1:0] PH_SLOW  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RECOV = 2'd1;
    localparam logic [PHASE_W-1:0] PH_AVOID = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SSTHRESH = 1'd1;

    typedef struct packed {
        logic apply_event;  // apply the input beat and update the window state
        logic emit;         // load the next result into the output register
    } ctl_cmd_t;

    typedef struct packed {
        logic emit_last;    // the result that would be loaded now ends the item
    } dp_status_t;

    // Bound a threshold to 1..MAX_CWND.
    function automatic logic [WIN_W-1:0] clamp_thresh(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] r;
        r = v;
        if (v == '0) r = 6'd1;
        else if (v > MAX_CWND) r = MAX_CWND;
        return r;
    endfunction

endpackage

// ===== rtl/core/rsc_ctrl.sv =====
// Controller state machine: input acceptance and pacing of result beats.
module rsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  rsc_pkg::dp_status_t stat,
    output rsc_pkg::ctl_cmd_t   cmd
);
    import rsc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    // Output slot takes a beat when empty or being drained this cycle.
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd.apply_event = 1'b0;
        cmd.emit        = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.apply_event = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/rsc_datapath.sv =====
// Datapath: configuration, window and congestion state, result register.
module rsc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rsc_pkg::ctl_cmd_t                   cmd,
    output rsc_pkg::dp_status_t                 stat,
    input  logic [rsc_pkg::REQ_W-1:0]           req_type,
    input  logic [rsc_pkg::SEQ_W-1:0]           ack_seq,
    input  logic                                ack_check_ok,
    input  logic                                cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic                                send_valid,
    output logic [rsc_pkg::IDX_W-1:0]           packet_index,
    output logic [rsc_pkg::SEQ_W-1:0]           packet_seq,
    output logic                                is_retransmit,
    output logic [rsc_pkg::WIN_W-1:0]           window_size,
    output logic [rsc_pkg::PHASE_W-1:0]         phase,
    output logic                                transfer_done,
    output logic                                last
);
    import rsc_pkg::*;

    // Configuration
    logic [IDX_W-1:0]   total_reg;
    logic [WIN_W-1:0]   init_ss_reg;

    // Window and congestion state
    logic [IDX_W-1:0]   ack_base_reg, ack_base_next;
    logic [IDX_W-1:0]   nts_reg, nts_next;
    logic [WIN_W-1:0]   cwnd_reg, cwnd_next;
    logic [WIN_W-1:0]   ssthresh_reg, ssthresh_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [DUP_W-1:0]   dup_reg, dup_next;
    logic [WIN_W-1:0]   avoid_reg, avoid_next;
    logic               retx_pend_reg, retx_pend_next;

    // Result register
    logic               send_valid_reg;
    logic [IDX_W-1:0]   index_reg;
    logic               retx_out_reg;
    logic [WIN_W-1:0]   window_reg;
    logic [PHASE_W-1:0] phase_out_reg;
    logic               done_out_reg;
    logic               last_reg;

    logic               done;
    logic [SEQ_W-1:0]   advance;
    logic [IDX_W-1:0]   outstanding;
    logic [IDX_W-1:0]   outstanding_inc;
    logic               can_send;
    logic               can_send_after;
    logic [WIN_W-1:0]   cwnd_grown;
    logic [WIN_W-1:0]   half_thresh;
    logic [WIN_W:0]     recov_cwnd;
    logic [DUP_W:0]     dup_inc;
    logic [WIN_W-1:0]   avoid_inc;
    logic [IDX_W-1:0]   nts_inc;

    assign done            = (ack_base_reg >= total_reg);
    assign advance         = ack_seq + 8'd1 - ack_base_reg[SEQ_W-1:0];
    assign outstanding     = nts_reg - ack_base_reg;
    assign outstanding_inc = outstanding + 16'd1;
    assign nts_inc         = nts_reg + 16'd1;
    assign can_send        = (nts_reg < total_reg) && (outstanding < {10'd0, cwnd_reg});
    assign can_send_after  = (nts_inc < total_reg) && (outstanding_inc < {10'd0, cwnd_reg});
    assign cwnd_grown      = (cwnd_reg < MAX_CWND) ? cwnd_reg + 6'd1 : cwnd_reg;
    assign half_thresh     = clamp_thresh(cwnd_reg >> 1);
    assign recov_cwnd      = {1'b0, half_thresh} + {1'b0, RECOV_INFLATE};
    assign dup_inc         = {1'b0, dup_reg} + 3'd1;
    assign avoid_inc       = avoid_reg + 6'd1;

    // Pending fast retransmit goes first, then new sends, else one status beat.
    assign stat.emit_last  = retx_pend_reg ? !can_send :
                             can_send      ? !can_send_after : 1'b1;

    always_comb
    begin
        ack_base_next  = ack_base_reg;
        nts_next       = nts_reg;
        cwnd_next      = cwnd_reg;
        ssthresh_next  = ssthresh_reg;
        phase_next     = phase_reg;
        dup_next       = dup_reg;
        avoid_next     = avoid_reg;
        retx_pend_next = retx_pend_reg;
        if (cmd.apply_event)
        begin
            retx_pend_next = 1'b0;
            case (req_type)
                REQ_START:
                begin
                    ack_base_next = '0;
                    nts_next      = '0;
                    cwnd_next     = 6'd1;
                    ssthresh_next = clamp_thresh(init_ss_reg);
                    phase_next    = PH_SLOW;
                    dup_next      = '0;
                    avoid_next    = '0;
                end
                REQ_ACK:
                begin
                    if (!done)
                    begin
                        if (!ack_check_ok)
                        begin
                            // Corrupt ack: go back to the oldest unacked packet.
                            nts_next = ack_base_reg;
                        end
                        else if (advance == '0)
                        begin
                            if (phase_reg == PH_RECOV)
                            begin
                                cwnd_next = cwnd_grown;
                            end
                            else if (dup_inc >= DUP_THRESH)
                            begin
                                ssthresh_next  = half_thresh;
                                cwnd_next      = (recov_cwnd > {1'b0, MAX_CWND}) ?
                                                 MAX_CWND : recov_cwnd[WIN_W-1:0];
                                phase_next     = PH_RECOV;
                                dup_next       = '0;
                                avoid_next     = '0;
                                retx_pend_next = 1'b1;
                            end
                            else
                            begin
                                dup_next = dup_inc[DUP_W-1:0];
                            end
                        end
                        else if ({8'd0, advance} <= outstanding)
                        begin
                            ack_base_next = ack_base_reg + {8'd0, advance};
                            dup_next      = '0;
                            case (phase_reg)
                                PH_SLOW:
                                begin
                                    cwnd_next = cwnd_grown;
                                    if (cwnd_grown > ssthresh_reg)
                                    begin
                                        phase_next = PH_AVOID;
                                        avoid_next = '0;
                                    end
                                end
                                PH_RECOV:
                                begin
                                    cwnd_next  = ssthresh_reg;
                                    phase_next = PH_AVOID;
                                    avoid_next = '0;
                                end
                                default:
                                begin
                                    if (avoid_inc >= cwnd_reg)
                                    begin
                                        avoid_next = '0;
                                        cwnd_next  = cwnd_grown;
                                    end
                                    else
                                    begin
                                        avoid_next = avoid_inc;
                                    end
                                end
                            endcase
                        end
                    end
                end
                REQ_TIMEOUT:
                begin
                    if (!done)
                    begin
                        nts_next      = ack_base_reg;
                        ssthresh_next = half_thresh;
                        cwnd_next     = 6'd1;
                        phase_next    = PH_SLOW;
                        dup_next      = '0;
                        avoid_next    = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.emit)
        begin
            if (retx_pend_reg)
            begin
                retx_pend_next = 1'b0;
            end
            else if (can_send)
            begin
                nts_next = nts_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= 16'd1;
            init_ss_reg   <= INIT_SSTHRESH;
            ack_base_reg  <= '0;
            nts_reg       <= '0;
            cwnd_reg      <= 6'd1;
            ssthresh_reg  <= clamp_thresh(INIT_SSTHRESH);
            phase_reg     <= PH_SLOW;
            dup_reg       <= '0;
            avoid_reg     <= '0;
            retx_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOTAL_PACKETS: total_reg   <= cfg_wdata;
                    CFG_INIT_SSTHRESH: init_ss_reg <= cfg_wdata[WIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            ack_base_reg  <= ack_base_next;
            nts_reg       <= nts_next;
            cwnd_reg      <= cwnd_next;
            ssthresh_reg  <= ssthresh_next;
            phase_reg     <= phase_next;
            dup_reg       <= dup_next;
            avoid_reg     <= avoid_next;
            retx_pend_reg <= retx_pend_next;
        end
    end

    // Result register; window, phase and done reflect the state after the event.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            window_reg    <= cwnd_reg;
            phase_out_reg <= phase_reg;
            done_out_reg  <= done;
            last_reg      <= stat.emit_last;
            if (retx_pend_reg)
            begin
                send_valid_reg <= 1'b1;
                index_reg      <= ack_base_reg;
                retx_out_reg   <= 1'b1;
            end
            else if (can_send)
            begin
                send_valid_reg <= 1'b1;
                index_reg      <= nts_reg;
                retx_out_reg   <= 1'b0;
            end
            else
            begin
                send_valid_reg <= 1'b0;
                index_reg      <= '0;
                retx_out_reg   <= 1'b0;
            end
        end
    end

    assign send_valid    = send_valid_reg;
    assign packet_index  = index_reg;
    assign packet_seq    = index_reg[SEQ_W-1:0];
    assign is_retransmit = retx_out_reg;
    assign window_size   = window_reg;
    assign phase         = phase_out_reg;
    assign transfer_done = done_out_reg;
    assign last          = last_reg;

endmodule

// ===== rtl/core/reno_sender_window_control.sv =====
// Top level of the Reno sender window control block.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per beat: start of
//   a transfer, an ack with its sequence and checksum verdict, or a timeout.
//   Output channel (out_valid / out_stall) carries send commands: an optional
//   fast retransmit first, then new packets that fill the window, or a single
//   status beat with send_valid low when nothing is to be sent. The final beat
//   of each event carries last.
//   The event is applied in the cycle it is accepted; its results are then
//   loaded into the output register in turn. Results leave at one beat per
//   cycle from the send pointer while the output is not stalled; the send
//   pointer increment and the single output register set that pace.
//   in_stall is high while results of the current event are still being
//   produced; it drops once the last result sits in the output register, so
//   the next event may enter while that beat waits.
//   A stalled output holds its beat and freezes result generation.
//   Reset: total_packets = 1, initial_ssthresh = 32, and the window state of a
//   freshly started transfer. Configuration writes (cfg_we, cfg_index,
//   cfg_wdata) take effect at once and belong to idle periods.
module reno_sender_window_control (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rsc_pkg::REQ_W-1:0]           req_type,
    input  logic [rsc_pkg::SEQ_W-1:0]           ack_seq,
    input  logic                                ack_check_ok,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                send_valid,
    output logic [rsc_pkg::IDX_W-1:0]           packet_index,
    output logic [rsc_pkg::SEQ_W-1:0]           packet_seq,
    output logic                                is_retransmit,
    output logic [rsc_pkg::WIN_W-1:0]           window_size,
    output logic [rsc_pkg::PHASE_W-1:0]         phase,
    output logic                                transfer_done,
    output logic                                last
);
    import rsc_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t stat;

    // Sequence events and pace result beats.
    rsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the window state and build each result beat.
    rsc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .ack_seq       (ack_seq),
        .ack_check_ok  (ack_check_ok),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .send_valid    (send_valid),
        .packet_index  (packet_index),
        .packet_seq    (packet_seq),
        .is_retransmit (is_retransmit),
        .window_size   (window_size),
        .phase         (phase),
        .transfer_done (transfer_done),
        .last          (last)
    );

endmodule
